@@ sv/tbsr_pkg.sv @@
// shared types and constants for the tcp byte stream reassembler
package tbsr_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int INDEX_W      = 32;
  localparam int BYTE_W       = 8;
  localparam int COUNT_W      = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RELEASE
  } state_t;

endpackage

@@ sv/tbsr_byte_ram.sv @@
// byte store ring memory, one write and one registered read port
module tbsr_byte_ram
  import tbsr_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/tbsr_ctrl.sv @@
// window check, valid marks, run scan and in-order release sequencing
module tbsr_ctrl
  import tbsr_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = 6,
  parameter int CNT_W    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [INDEX_W-1:0] stream_index,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               has_byte,
  input  logic               segment_last,
  input  logic               end_of_stream,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [BYTE_W-1:0]  ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  logic [BYTE_W-1:0]  ram_rdata,
  output logic               strobe,
  output logic               byte_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               stream_done,
  output logic [COUNT_W-1:0] unassembled_count,
  output logic               last
);

  state_t state, state_next;

  logic [CAPACITY-1:0] valid;
  logic [AW-1:0]       read_ptr;
  logic [AW-1:0]       scan_ptr;
  logic [CNT_W-1:0]    run;
  logic [CNT_W-1:0]    remain;
  logic [INDEX_W-1:0]  next_expected;
  logic [INDEX_W-1:0]  eof_position;
  logic                eof_known;
  logic [COUNT_W-1:0]  held;
  logic                ended;

  logic                accept;
  logic [INDEX_W-1:0]  offset;
  logic                in_window;
  logic [AW:0]         slot_sum;
  logic [AW-1:0]       slot;
  logic                scan_go;
  logic [INDEX_W-1:0]  next_final;
  logic [AW-1:0]       scan_ptr_inc;
  logic [AW-1:0]       read_ptr_inc;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign offset    = stream_index - next_expected;
  assign in_window = (offset < INDEX_W'(CAPACITY));
  assign slot_sum  = {1'b0, read_ptr} + {1'b0, offset[AW-1:0]};
  assign slot      = (slot_sum >= (AW+1)'(CAPACITY)) ?
                     AW'(slot_sum - (AW+1)'(CAPACITY)) : slot_sum[AW-1:0];

  assign scan_go      = (run < CNT_W'(CAPACITY)) && valid[scan_ptr];
  assign next_final   = next_expected + INDEX_W'(run);
  assign scan_ptr_inc = (scan_ptr == AW'(CAPACITY - 1)) ? '0 : scan_ptr + AW'(1);
  assign read_ptr_inc = (read_ptr == AW'(CAPACITY - 1)) ? '0 : read_ptr + AW'(1);

  assign ram_we    = accept && has_byte && in_window;
  assign ram_waddr = slot;
  assign ram_wdata = data_byte;
  assign ram_re    = (state == ST_RELEASE);
  assign ram_raddr = read_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_go) state_next = (run == '0) ? ST_IDLE : ST_RELEASE;
      end
      ST_RELEASE: begin
        if (remain == CNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      read_ptr      <= '0;
      scan_ptr      <= '0;
      run           <= '0;
      remain        <= '0;
      next_expected <= '0;
      eof_position  <= '0;
      eof_known     <= 1'b0;
      held          <= '0;
      ended         <= 1'b0;
      strobe        <= 1'b0;
      byte_valid    <= 1'b0;
      last          <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      byte_valid <= 1'b0;
      last       <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (has_byte && in_window) begin
              valid[slot] <= 1'b1;
              if (!valid[slot]) held <= held + COUNT_W'(1);
            end
            if (segment_last && end_of_stream) begin
              eof_position <= stream_index + INDEX_W'(has_byte);
              eof_known    <= 1'b1;
            end
            scan_ptr <= read_ptr;
            run      <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            run      <= run + CNT_W'(1);
            scan_ptr <= scan_ptr_inc;
          end else begin
            next_expected <= next_final;
            held          <= held - COUNT_W'(run);
            if (eof_known && (next_final == eof_position)) ended <= 1'b1;
            remain <= run;
            if (run == '0) begin
              strobe <= 1'b1;
              last   <= 1'b1;
            end
          end
        end
        ST_RELEASE: begin
          valid[read_ptr] <= 1'b0;
          read_ptr        <= read_ptr_inc;
          remain          <= remain - CNT_W'(1);
          strobe          <= 1'b1;
          byte_valid      <= 1'b1;
          last            <= (remain == CNT_W'(1));
        end
        default: begin
        end
      endcase
    end
  end

  assign out_byte          = byte_valid ? ram_rdata : '0;
  assign stream_done       = ended;
  assign unassembled_count = held;

  // an empty result is always the only one of its item
  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    strobe && !byte_valid |-> last)
    else $error("empty result without last");

  // every memory read turns into a released word on the next cycle
  a_read_strobe: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> strobe && byte_valid)
    else $error("memory read without released word");

  // while idle, the held count matches the marked slots
  a_held_marks: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> $countones(valid) == int'(held))
    else $error("held count out of step with valid marks");

  // the held count never exceeds the ring size
  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    int'(held) <= CAPACITY)
    else $error("held count beyond capacity");

  // no new word is taken while a release is under way
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_RELEASE |-> !ram_we)
    else $error("write during release");

endmodule

@@ sv/tcp_byte_stream_reassembler.sv @@
// top level of the tcp byte stream reassembler
// A word is taken when start is high and busy is low. Each word writes its byte
// into the ring at most once, then the controller scans the valid marks from the
// read pointer one slot per cycle to size the in-order run, and then releases the
// run from the byte memory one byte per cycle. Busy stays high through the scan and
// the release, so the next item is taken only after the whole run is released.
// Results come one per cycle on strobe, the last one in the first cycle with busy low;
// each must be taken in the cycle it is shown, since there is no stall.
// stream_done and unassembled_count carry the values after the whole item.
module tcp_byte_stream_reassembler
  import tbsr_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [INDEX_W-1:0] stream_index,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               has_byte,
  input  logic               segment_last,
  input  logic               end_of_stream,
  output logic               strobe,
  output logic               byte_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               stream_done,
  output logic [COUNT_W-1:0] unassembled_count,
  output logic               last
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  tbsr_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .stream_index      (stream_index),
    .data_byte         (data_byte),
    .has_byte          (has_byte),
    .segment_last      (segment_last),
    .end_of_stream     (end_of_stream),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .strobe            (strobe),
    .byte_valid        (byte_valid),
    .out_byte          (out_byte),
    .stream_done       (stream_done),
    .unassembled_count (unassembled_count),
    .last              (last)
  );

  tbsr_byte_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
